/* hdl/ccdp_pkg.sv */
// Shared types and constants of the copy control descriptor parser.
package ccdp_pkg;

    localparam logic [7:0] C_DESC_TAG  = 8'hC1;
    localparam int         C_RATE_BIT  = 5;
    localparam int         C_LOOP_BIT  = 4;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_SHORT = 3'd1,
        ST_BAD_TAG   = 3'd2,
        ST_SIZE      = 3'd3,
        ST_ZERO_LEN  = 3'd4,
        ST_OVERRUN   = 3'd5
    } t_status;

    typedef enum logic [9:0] {
        PH_TAG     = 10'b00_0000_0001,
        PH_LEN     = 10'b00_0000_0010,
        PH_HDR     = 10'b00_0000_0100,
        PH_RATE    = 10'b00_0000_1000,
        PH_LOOPLEN = 10'b00_0001_0000,
        PH_CTAG    = 10'b00_0010_0000,
        PH_CFLAGS  = 10'b00_0100_0000,
        PH_CRATE   = 10'b00_1000_0000,
        PH_PAD     = 10'b01_0000_0000,
        PH_DRAIN   = 10'b10_0000_0000
    } t_phase;

    typedef struct packed {
        logic       record_kind;
        t_status    status;
        logic [1:0] recording_control;
        logic       bitrate_flag;
        logic [7:0] max_bitrate;
        logic       component_flag;
        logic [3:0] user_bits;
        logic [7:0] comp_tag;
        logic [7:0] length_seen;
        logic [8:0] consumed_size;
        logic [6:0] component_count;
        logic       last;
    } t_result;

    // Up to two results per accepted byte, first slot filled first.
    typedef struct packed {
        logic    first_valid;
        logic    second_valid;
        t_result first;
        t_result second;
    } t_push;

endpackage

/* hdl/ccdp_if.sv */
// Byte and result channel interfaces of the descriptor parser.
interface ccdp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface ccdp_result_if;
    logic       valid;
    logic       ready;
    logic       record_kind;
    logic [2:0] status;
    logic [1:0] recording_control;
    logic       bitrate_flag;
    logic [7:0] max_bitrate;
    logic       component_flag;
    logic [3:0] user_bits;
    logic [7:0] comp_tag;
    logic [7:0] length_seen;
    logic [8:0] consumed_size;
    logic [6:0] component_count;
    logic       last;

    modport source (
        output valid, output record_kind, output status, output recording_control,
        output bitrate_flag, output max_bitrate, output component_flag,
        output user_bits, output comp_tag, output length_seen,
        output consumed_size, output component_count, output last, input ready
    );
    modport sink (
        input valid, input record_kind, input status, input recording_control,
        input bitrate_flag, input max_bitrate, input component_flag,
        input user_bits, input comp_tag, input length_seen,
        input consumed_size, input component_count, input last, output ready
    );
endinterface

/* hdl/ccdp_parse.sv */
// Byte-wise parse state machine; builds the results each accepted byte causes.
module ccdp_parse
    import ccdp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_buffer_end,
    output t_push      o_push
);

    t_phase      r_phase,     n_phase;
    logic [7:0]  r_decl_len,  n_decl_len;
    logic [7:0]  r_body_cnt,  n_body_cnt;
    logic [7:0]  r_loop_len,  n_loop_len;
    logic [7:0]  r_loop_cnt,  n_loop_cnt;
    logic [15:0] r_hdr,       n_hdr;
    logic [15:0] r_entry,     n_entry;
    logic [6:0]  r_total,     n_total;

    logic       rec;
    logic [7:0] rec_rate;
    logic       body;
    logic       decl_end;
    logic       sum_valid;
    t_status    sum_status;
    logic [7:0] sum_len;
    t_result    rec_res;
    t_result    sum_res;

    always_comb begin
        n_phase    = r_phase;
        n_decl_len = r_decl_len;
        n_body_cnt = r_body_cnt;
        n_loop_len = r_loop_len;
        n_loop_cnt = r_loop_cnt;
        n_hdr      = r_hdr;
        n_entry    = r_entry;
        n_total    = r_total;
        rec        = 1'b0;
        rec_rate   = 8'd0;
        body       = 1'b0;
        decl_end   = 1'b0;
        sum_valid  = 1'b0;
        sum_status = ST_OK;
        sum_len    = 8'd0;

        case (r_phase)
            PH_TAG: begin
                // start of a new descriptor: clear everything
                n_decl_len = 8'd0;
                n_body_cnt = 8'd0;
                n_loop_len = 8'd0;
                n_loop_cnt = 8'd0;
                n_hdr      = 16'd0;
                n_entry    = 16'd0;
                n_total    = 7'd0;
                if (i_buffer_end) begin
                    sum_valid  = 1'b1;
                    sum_status = ST_TOO_SHORT;
                    n_phase    = PH_TAG;
                end else if (i_data_byte != C_DESC_TAG) begin
                    sum_valid  = 1'b1;
                    sum_status = ST_BAD_TAG;
                    n_phase    = PH_DRAIN;
                end else begin
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_decl_len = i_data_byte;
                n_body_cnt = 8'd0;
                if (i_data_byte == 8'd0) begin
                    sum_valid  = 1'b1;
                    sum_status = ST_ZERO_LEN;
                    sum_len    = i_data_byte;
                    n_phase    = i_buffer_end ? PH_TAG : PH_DRAIN;
                end else if (i_buffer_end) begin
                    sum_valid  = 1'b1;
                    sum_status = ST_SIZE;
                    sum_len    = i_data_byte;
                    n_phase    = PH_TAG;
                end else begin
                    n_phase = PH_HDR;
                end
            end
            PH_DRAIN: begin
                if (i_buffer_end) begin
                    n_phase = PH_TAG;
                end
            end
            PH_HDR: begin
                body  = 1'b1;
                n_hdr = {i_data_byte, 8'd0};
                if (i_data_byte[C_RATE_BIT]) begin
                    n_phase = PH_RATE;
                end else if (i_data_byte[C_LOOP_BIT]) begin
                    n_phase = PH_LOOPLEN;
                end else begin
                    n_phase = PH_PAD;
                end
            end
            PH_RATE: begin
                body  = 1'b1;
                n_hdr = {r_hdr[15:8], i_data_byte};
                n_phase = r_hdr[8 + C_LOOP_BIT] ? PH_LOOPLEN : PH_PAD;
            end
            PH_LOOPLEN: begin
                body       = 1'b1;
                n_loop_len = i_data_byte;
                n_loop_cnt = 8'd0;
                n_phase    = (i_data_byte != 8'd0) ? PH_CTAG : PH_PAD;
            end
            PH_CTAG: begin
                body       = 1'b1;
                n_entry    = {i_data_byte, 8'd0};
                n_loop_cnt = r_loop_cnt + 8'd1;
                n_phase    = PH_CFLAGS;
            end
            PH_CFLAGS: begin
                body       = 1'b1;
                n_entry    = {r_entry[15:8], i_data_byte};
                n_loop_cnt = r_loop_cnt + 8'd1;
                if (i_data_byte[C_RATE_BIT]) begin
                    n_phase = PH_CRATE;
                end else begin
                    rec     = 1'b1;
                    n_phase = (n_loop_cnt < r_loop_len) ? PH_CTAG : PH_PAD;
                end
            end
            PH_CRATE: begin
                body       = 1'b1;
                n_loop_cnt = r_loop_cnt + 8'd1;
                rec        = 1'b1;
                rec_rate   = i_data_byte;
                n_phase    = (n_loop_cnt < r_loop_len) ? PH_CTAG : PH_PAD;
            end
            PH_PAD: begin
                body = 1'b1;
            end
            default: begin
                n_phase = PH_TAG;
            end
        endcase

        if (body) begin
            n_body_cnt = r_body_cnt + 8'd1;
            decl_end   = (n_body_cnt == r_decl_len);
            if (rec) begin
                n_total = r_total + 7'd1;
            end
            if (decl_end) begin
                // parsing must have finished by the declared end
                sum_valid  = 1'b1;
                sum_status = (n_phase == PH_PAD) ? ST_OK : ST_OVERRUN;
                sum_len    = r_decl_len;
                n_phase    = i_buffer_end ? PH_TAG : PH_DRAIN;
            end else if (i_buffer_end) begin
                sum_valid  = 1'b1;
                sum_status = ST_SIZE;
                sum_len    = r_decl_len;
                n_phase    = PH_TAG;
            end
        end
    end

    always_comb begin
        rec_res.record_kind       = 1'b0;
        rec_res.status            = ST_OK;
        rec_res.recording_control = n_entry[7:6];
        rec_res.bitrate_flag      = n_entry[5];
        rec_res.max_bitrate       = rec_rate;
        rec_res.component_flag    = 1'b0;
        rec_res.user_bits         = n_entry[3:0];
        rec_res.comp_tag          = n_entry[15:8];
        rec_res.length_seen       = r_decl_len;
        rec_res.consumed_size     = 9'd0;
        rec_res.component_count   = n_total;
        rec_res.last              = ~(decl_end | i_buffer_end);

        sum_res.record_kind       = 1'b1;
        sum_res.status            = sum_status;
        sum_res.recording_control = n_hdr[15:14];
        sum_res.bitrate_flag      = n_hdr[13];
        sum_res.max_bitrate       = n_hdr[7:0];
        sum_res.component_flag    = n_hdr[12];
        sum_res.user_bits         = n_hdr[11:8];
        sum_res.comp_tag          = 8'd0;
        sum_res.length_seen       = sum_len;
        sum_res.consumed_size     = (sum_status == ST_OK) ? (9'd2 + {1'b0, sum_len}) : 9'd0;
        sum_res.component_count   = n_total;
        sum_res.last              = 1'b1;

        o_push.first_valid  = i_accept & (rec | sum_valid);
        o_push.second_valid = i_accept & rec & sum_valid;
        o_push.first        = rec ? rec_res : sum_res;
        o_push.second       = sum_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_TAG;
            r_decl_len <= 8'd0;
            r_body_cnt <= 8'd0;
            r_loop_len <= 8'd0;
            r_loop_cnt <= 8'd0;
            r_hdr      <= 16'd0;
            r_entry    <= 16'd0;
            r_total    <= 7'd0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_decl_len <= n_decl_len;
            r_body_cnt <= n_body_cnt;
            r_loop_len <= n_loop_len;
            r_loop_cnt <= n_loop_cnt;
            r_hdr      <= n_hdr;
            r_entry    <= n_entry;
            r_total    <= n_total;
        end
    end

endmodule

/* hdl/ccdp_queue.sv */
// Result queue: takes up to two results a cycle, hands out one.
module ccdp_queue
    import ccdp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_result       r_slot [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;
    logic [PW-1:0] wr_next;
    logic          do_pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign do_pop  = i_pop & (r_count != '0);
    assign wr_next = ptr_inc(r_wr_ptr);
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rd_ptr];
    // keep space for the two results one byte may cause
    assign o_room  = (r_count <= CW'(DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        if (i_push.second_valid) begin
            n_wr_ptr = ptr_inc(wr_next);
        end else if (i_push.first_valid) begin
            n_wr_ptr = wr_next;
        end
        n_rd_ptr = do_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CW'(i_push.first_valid) + CW'(i_push.second_valid)
                   - CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.first_valid) begin
            r_slot[r_wr_ptr] <= i_push.first;
        end
        if (i_push.second_valid) begin
            r_slot[wr_next] <= i_push.second;
        end
    end

endmodule

/* hdl/copy_control_descriptor_parser_unit.sv */
// Digital copy control descriptor parser, top level.
//
// i_byte carries the descriptor buffer one byte per item: data_byte and
// buffer_end, which marks the last byte of the buffer. o_result carries one
// result per item: a component record each time a record completes, and a
// summary (record_kind = 1) with status and consumed size when the
// descriptor ends or fails. Records stay tentative until their summary.
//
// Throughput: one byte per cycle while the queue has room. A byte causes
// zero, one or two results; each is registered in the result queue of
// P_QUEUE_DEPTH entries when the byte is accepted and appears on o_result
// in order, so the queue absorbs the second result of a byte.
// i_byte.ready is high while the queue has room for two results, so a
// stalled receiver fills the queue and then holds off the byte channel;
// nothing is dropped and held results stay stable.
// Reset (synchronous, active low) empties the queue and puts the parser
// back to expecting a tag byte.
module copy_control_descriptor_parser_unit
    import ccdp_pkg::*;
#(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ccdp_byte_if.sink     i_byte,
    ccdp_result_if.source o_result
);

    logic    accept;
    logic    room;
    t_push   push;
    t_result head;

    assign i_byte.ready = room;
    assign accept       = i_byte.valid & room;

    ccdp_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_byte.data_byte),
        .i_buffer_end (i_byte.buffer_end),
        .o_push       (push)
    );

    ccdp_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_result.ready),
        .o_room  (room),
        .o_valid (o_result.valid),
        .o_head  (head)
    );

    assign o_result.record_kind       = head.record_kind;
    assign o_result.status            = head.status;
    assign o_result.recording_control = head.recording_control;
    assign o_result.bitrate_flag      = head.bitrate_flag;
    assign o_result.max_bitrate       = head.max_bitrate;
    assign o_result.component_flag    = head.component_flag;
    assign o_result.user_bits         = head.user_bits;
    assign o_result.comp_tag          = head.comp_tag;
    assign o_result.length_seen       = head.length_seen;
    assign o_result.consumed_size     = head.consumed_size;
    assign o_result.component_count   = head.component_count;
    assign o_result.last              = head.last;

endmodule

/* hdl/ccdp_checker.sv */
// Port-level checks on the parser's result channel, bound to the top level.
module ccdp_checker
    import ccdp_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_record_kind,
    input logic [2:0] i_status,
    input logic       i_component_flag,
    input logic [7:0] i_length_seen,
    input logic [8:0] i_consumed_size,
    input logic       i_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    a_record_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_record_kind |->
            i_status == ST_OK && i_consumed_size == 9'd0 && !i_component_flag)
        else $error("component record carries summary fields");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_record_kind |-> i_last)
        else $error("summary item not marked last");

    a_ok_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_record_kind && i_status == ST_OK |->
            i_consumed_size == 9'd2 + {1'b0, i_length_seen} && i_length_seen != 8'd0)
        else $error("consumed size does not match declared length");

    a_err_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_record_kind && i_status != ST_OK |->
            i_consumed_size == 9'd0 && i_status <= ST_OVERRUN)
        else $error("failed summary has bad status or size");

endmodule

bind copy_control_descriptor_parser_unit ccdp_checker u_ccdp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_record_kind    (o_result.record_kind),
    .i_status         (o_result.status),
    .i_component_flag (o_result.component_flag),
    .i_length_seen    (o_result.length_seen),
    .i_consumed_size  (o_result.consumed_size),
    .i_last           (o_result.last)
);

/* bench/testbench.sv */
// Self-checking bench for the copy control descriptor parser: byte driver, result monitor.
`timescale 1ns / 1ps

module testbench;
    import ccdp_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } t_byte_item;

    localparam int C_STALL_LIMIT = 1000;
    localparam int C_LONG_HOLD   = 120;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ccdp_byte_if   byte_ch ();
    ccdp_result_if res_ch ();

    copy_control_descriptor_parser_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch),
        .o_result (res_ch)
    );

    always #6 i_clk = ~i_clk;

    // Bytes waiting for the driver, results the parser owes us.
    t_byte_item byte_backlog[$];
    t_result    expected_results[$];
    logic [7:0] frame[$];

    int mismatches   = 0;
    int queued_bytes = 0;
    int res_total    = 0;
    int send_gap     = 0;
    int rcv_gap      = 0;
    int hold_left    = 0;
    int holds_done   = 0;
    int idle_cycles  = 0;
    bit idling_on    = 1'b1;

    // Parser state mirrored by the predictor.
    t_phase     parse_phase  = PH_TAG;
    logic [7:0] decl_len     = '0;
    logic [7:0] body_cnt     = '0;
    logic [7:0] loop_len     = '0;
    logic [7:0] loop_cnt     = '0;
    logic [15:0] hdr_fields  = '0;
    logic [15:0] entry_fields = '0;
    logic [6:0] rec_total    = '0;

    task automatic report_error(string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("ERROR t=%0t result %0d: %s", $time, res_total, msg);
    endtask

    task automatic cmp_field(string name, logic [8:0] got, logic [8:0] want);
        if (got !== want)
            report_error($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    function automatic t_result make_result(logic kind, t_status st, logic [7:0] flags,
                                            logic [7:0] rate, logic cflag, logic [7:0] tag,
                                            logic [7:0] len, logic [8:0] consumed,
                                            logic last);
        t_result r;
        r.record_kind       = kind;
        r.status            = st;
        r.recording_control = flags[7:6];
        r.bitrate_flag      = flags[C_RATE_BIT];
        r.max_bitrate       = rate;
        r.component_flag    = cflag;
        r.user_bits         = flags[3:0];
        r.comp_tag          = tag;
        r.length_seen       = len;
        r.consumed_size     = consumed;
        r.component_count   = rec_total;
        r.last              = last;
        return r;
    endfunction

    task automatic push_summary(t_status st, logic [7:0] len);
        logic [7:0] hdr;
        logic [8:0] consumed;
        hdr = hdr_fields[15:8];
        consumed = (st == ST_OK) ? 9'(len) + 9'd2 : 9'd0;
        expected_results = {expected_results,
                            make_result(1'b1, st, hdr, hdr_fields[7:0], hdr[C_LOOP_BIT],
                                        8'h00, len, consumed, 1'b1)};
    endtask

    task automatic push_record(logic [7:0] rate, logic last);
        rec_total++;
        expected_results = {expected_results,
                            make_result(1'b0, ST_OK, entry_fields[7:0], rate, 1'b0,
                                        entry_fields[15:8], decl_len, 9'd0, last)};
    endtask

    function automatic t_phase loop_next();
        if (loop_cnt < loop_len)
            return PH_CTAG;
        return PH_PAD;
    endfunction

    // Advance the mirrored parser by one byte and queue the results it causes.
    task automatic predict_descriptor_byte(logic [7:0] b, logic fin);
        logic       rec;
        logic [7:0] rec_rate;
        logic [7:0] hdr;
        logic       decl_end;
        rec      = 1'b0;
        rec_rate = 8'h00;
        hdr      = hdr_fields[15:8];
        case (parse_phase)
            PH_TAG: begin
                decl_len     = '0;
                body_cnt     = '0;
                loop_len     = '0;
                loop_cnt     = '0;
                hdr_fields   = '0;
                entry_fields = '0;
                rec_total    = '0;
                if (fin) begin
                    push_summary(ST_TOO_SHORT, 8'h00);
                end else if (b != C_DESC_TAG) begin
                    push_summary(ST_BAD_TAG, 8'h00);
                    parse_phase = PH_DRAIN;
                end else begin
                    parse_phase = PH_LEN;
                end
                return;
            end
            PH_LEN: begin
                decl_len = b;
                body_cnt = '0;
                if (b == 8'h00) begin
                    push_summary(ST_ZERO_LEN, b);
                    parse_phase = fin ? PH_TAG : PH_DRAIN;
                end else if (fin) begin
                    push_summary(ST_SIZE, b);
                    parse_phase = PH_TAG;
                end else begin
                    parse_phase = PH_HDR;
                end
                return;
            end
            PH_DRAIN: begin
                if (fin)
                    parse_phase = PH_TAG;
                return;
            end
            PH_HDR: begin
                hdr_fields = {b, 8'h00};
                if (b[C_RATE_BIT])
                    parse_phase = PH_RATE;
                else if (b[C_LOOP_BIT])
                    parse_phase = PH_LOOPLEN;
                else
                    parse_phase = PH_PAD;
            end
            PH_RATE: begin
                hdr_fields[7:0] = b;
                parse_phase = hdr[C_LOOP_BIT] ? PH_LOOPLEN : PH_PAD;
            end
            PH_LOOPLEN: begin
                loop_len    = b;
                loop_cnt    = '0;
                parse_phase = loop_next();
            end
            PH_CTAG: begin
                entry_fields = {b, 8'h00};
                loop_cnt++;
                parse_phase = PH_CFLAGS;
            end
            PH_CFLAGS: begin
                entry_fields[7:0] = b;
                loop_cnt++;
                if (b[C_RATE_BIT]) begin
                    parse_phase = PH_CRATE;
                end else begin
                    rec = 1'b1;
                    parse_phase = loop_next();
                end
            end
            PH_CRATE: begin
                loop_cnt++;
                rec      = 1'b1;
                rec_rate = b;
                parse_phase = loop_next();
            end
            PH_PAD: ;
            default: begin
                parse_phase = PH_TAG;
                return;
            end
        endcase

        body_cnt++;
        decl_end = (body_cnt == decl_len);
        if (rec)
            push_record(rec_rate, !(decl_end || fin));
        if (decl_end) begin
            push_summary((parse_phase == PH_PAD) ? ST_OK : ST_OVERRUN, decl_len);
            parse_phase = fin ? PH_TAG : PH_DRAIN;
        end else if (fin) begin
            push_summary(ST_SIZE, decl_len);
            parse_phase = PH_TAG;
        end
    endtask

    // Byte driver: present backlog items, idle in random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
        end else begin
            if (byte_ch.valid && byte_ch.ready)
                predict_descriptor_byte(byte_ch.data_byte, byte_ch.buffer_end);
            if (!byte_ch.valid || byte_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    byte_ch.valid <= 1'b0;
                end else if (idling_on && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 6);
                    byte_ch.valid <= 1'b0;
                end else if (byte_backlog.size() > 0) begin
                    t_byte_item item;
                    item = byte_backlog.pop_front();
                    byte_ch.valid      <= 1'b1;
                    byte_ch.data_byte  <= item.data;
                    byte_ch.buffer_end <= item.fin;
                end else begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, twice, so the result queue fills up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (idling_on && holds_done < 2 && res_total >= 150 + 80 * holds_done) begin
            hold_left  <= C_LONG_HOLD;
            holds_done <= holds_done + 1;
        end
    end

    // Result monitor: compare against the oldest expectation, stall at random.
    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                res_total++;
                if (expected_results.size() == 0) begin
                    report_error("result arrived with none expected");
                end else begin
                    want = expected_results.pop_front();
                    cmp_field("record_kind", 9'(res_ch.record_kind), 9'(want.record_kind));
                    cmp_field("status", 9'(res_ch.status), 9'(want.status));
                    cmp_field("recording_control", 9'(res_ch.recording_control),
                              9'(want.recording_control));
                    cmp_field("bitrate_flag", 9'(res_ch.bitrate_flag), 9'(want.bitrate_flag));
                    cmp_field("max_bitrate", 9'(res_ch.max_bitrate), 9'(want.max_bitrate));
                    cmp_field("component_flag", 9'(res_ch.component_flag),
                              9'(want.component_flag));
                    cmp_field("user_bits", 9'(res_ch.user_bits), 9'(want.user_bits));
                    cmp_field("comp_tag", 9'(res_ch.comp_tag), 9'(want.comp_tag));
                    cmp_field("length_seen", 9'(res_ch.length_seen), 9'(want.length_seen));
                    cmp_field("consumed_size", res_ch.consumed_size, want.consumed_size);
                    cmp_field("component_count", 9'(res_ch.component_count),
                              9'(want.component_count));
                    cmp_field("last", 9'(res_ch.last), 9'(want.last));
                end
            end
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
            end else if (rcv_gap > 0) begin
                rcv_gap--;
                res_ch.ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                rcv_gap = $urandom_range(0, 6);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= C_STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", C_STALL_LIMIT);
            $display("FAIL copy_control_descriptor_parser_unit");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b, logic fin);
        t_byte_item item;
        item.data = b;
        item.fin  = fin;
        byte_backlog = {byte_backlog, item};
        queued_bytes++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            send_byte(frame[i], i == frame.size() - 1);
        frame.delete();
    endtask

    // Build one buffer: mostly well-formed descriptors with random content,
    // some noise, truncation, short lengths, padding and trailing bytes.
    task automatic build_random_frame(bit big);
        logic [7:0] body[$];
        logic [7:0] recs[$];
        logic [7:0] hdr;
        logic [7:0] flags;
        int         n_rec;
        int         loop;
        int         decl;
        int         cut;
        frame.delete();
        if (!big && $urandom_range(0, 11) == 0) begin
            case ($urandom_range(0, 2))
                0: repeat ($urandom_range(1, 5)) frame = {frame, 8'($urandom)};
                1: begin
                    frame = {frame, C_DESC_TAG};
                    frame = {frame, 8'h00};
                    repeat ($urandom_range(0, 2)) frame = {frame, 8'($urandom)};
                end
                default: frame = {frame, ($urandom_range(0, 1) ? C_DESC_TAG : 8'($urandom))};
            endcase
            return;
        end
        hdr = 8'($urandom);
        if (big) begin
            hdr[C_RATE_BIT] = 1'b0;
            hdr[C_LOOP_BIT] = 1'b1;
        end else if ($urandom_range(0, 2) == 0) begin
            hdr[C_LOOP_BIT] = 1'b1;
        end
        body = {body, hdr};
        if (hdr[C_RATE_BIT])
            body = {body, 8'($urandom)};
        if (hdr[C_LOOP_BIT]) begin
            if (big)
                n_rec = 126;
            else if ($urandom_range(0, 15) == 0)
                n_rec = $urandom_range(5, 40);
            else
                n_rec = $urandom_range(0, 4);
            repeat (n_rec) begin
                recs = {recs, 8'($urandom)};
                flags = 8'($urandom);
                if (big)
                    flags[C_RATE_BIT] = 1'b0;
                recs = {recs, flags};
                if (flags[C_RATE_BIT])
                    recs = {recs, 8'($urandom)};
            end
            loop = recs.size();
            if (!big && $urandom_range(0, 7) == 0)
                loop = loop + $urandom_range(0, 6) - 3;
            if (loop < 0)
                loop = 0;
            if (loop > 255)
                loop = 255;
            body = {body, 8'(loop)};
            body = {body, recs};
        end
        decl = body.size();
        if (big) begin
            decl = 255;
        end else begin
            case ($urandom_range(0, 7))
                0: decl = decl + $urandom_range(1, 4);
                1: decl = $urandom_range(1, decl);
                default: ;
            endcase
        end
        if (decl > 255)
            decl = 255;
        frame = {frame, C_DESC_TAG};
        frame = {frame, 8'(decl)};
        for (int i = 0; i < decl; i++)
            frame = {frame, ((i < body.size()) ? body[i] : 8'($urandom))};
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) frame = {frame, 8'($urandom)};
        if (!big && $urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, frame.size());
            while (frame.size() > cut)
                void'(frame.pop_back());
        end
    endtask

    task automatic await_drain();
        while (byte_backlog.size() != 0 || byte_ch.valid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        i_rst_n            = 1'b0;
        byte_ch.valid      = 1'b0;
        byte_ch.data_byte  = 8'h00;
        byte_ch.buffer_end = 1'b0;
        res_ch.ready       = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Buffer ending on its tag byte.
        send_byte(8'h00, 1'b1);
        // Wrong tag, drained up to buffer end.
        send_byte(8'hFF, 1'b0);
        send_byte(8'h12, 1'b1);
        // Zero length ending the buffer, then zero length with trailing bytes.
        send_byte(C_DESC_TAG, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(C_DESC_TAG, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b1);
        // Buffer ends before the declared length.
        send_byte(C_DESC_TAG, 1'b0);
        send_byte(8'h05, 1'b0);
        send_byte(8'h30, 1'b1);
        // Full descriptor: bitrate, two records, last record and summary on one byte.
        send_byte(C_DESC_TAG, 1'b0);
        send_byte(8'h08, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h05, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h2F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h0F, 1'b1);
        // Declared length ends while the bitrate byte is still due.
        send_byte(C_DESC_TAG, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h77, 1'b1);
        // Leftover body byte after parsing completes, then the buffer ends early.
        send_byte(C_DESC_TAG, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h55, 1'b1);

        // Sender pause: let every expected result come back.
        await_drain();

        // Largest descriptor: 255 bytes, 126 records, consumed size 257.
        build_random_frame(1'b1);
        send_frame();
        while (queued_bytes < 550) begin
            build_random_frame(1'b0);
            send_frame();
        end

        await_drain();
        while (queued_bytes < 950) begin
            build_random_frame(1'b0);
            send_frame();
        end

        // Tail without idling on either side.
        while (byte_backlog.size() != 0)
            @(posedge i_clk);
        idling_on = 1'b0;
        while (queued_bytes < 1250) begin
            build_random_frame(1'b0);
            send_frame();
        end

        await_drain();
        repeat (20) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_results.size()));
        if (mismatches == 0)
            $display("PASS copy_control_descriptor_parser_unit");
        else
            $display("FAIL copy_control_descriptor_parser_unit");
        $finish;
    end

endmodule
